FILE: hdl/keypad_code_lock_core_defines.svh
// ---------------------------------------------------------------------------
// keypad code lock assertion macros
// concurrent check helpers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define KCL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KCL_ASSERT(lbl, ante, cons, msg)
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/kcl_pkg.sv
// ---------------------------------------------------------------------------
// kcl_pkg
// shared widths, codes and types of the keypad code lock
// ---------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int SYM_W     = 4;
  localparam int KIND_W    = 2;
  localparam int CHAN_W    = 2;
  localparam int CODE_W    = 64;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CH_SLOTS  = 4;

  localparam logic [SYM_W-1:0] SYM_STAR = 4'd14;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 2'd0,
    EV_ACTUATE = 2'd1,
    EV_REJECT  = 2'd2,
    EV_STRAY   = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_A = 3'd0,
    REG_CODE_B = 3'd1,
    REG_CODE_C = 3'd2,
    REG_CODE_D = 3'd3,
    REG_LEN_A  = 3'd4,
    REG_LEN_B  = 3'd5,
    REG_LEN_C  = 3'd6,
    REG_LEN_D  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    event_kind_t             kind;
    logic [CHAN_W-1:0]       chan;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/kcl_cell.sv
// ---------------------------------------------------------------------------
// kcl_cell
// one entry buffer position: holds a symbol and extends the per-channel
// match vector handed along from the previous position
// ---------------------------------------------------------------------------
`default_nettype none

module kcl_cell #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [kcl_pkg::SYM_W-1:0]                   sym_in,
  input  wire logic                                        active,
  input  wire logic [NUM_CHANNELS-1:0][kcl_pkg::SYM_W-1:0] code_sym,
  input  wire logic [NUM_CHANNELS-1:0]                     match_in,
  output      logic [NUM_CHANNELS-1:0]                     match_out
);

  logic [kcl_pkg::SYM_W-1:0] sym;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym <= sym_in;
    end
  end

  // positions past the entry length do not take part
  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      match_out[ch] = match_in[ch] & (!active || (sym == code_sym[ch]));
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kcl_out_buf.sv
// ---------------------------------------------------------------------------
// kcl_out_buf
// two-word output buffer: output register plus skid register
// ---------------------------------------------------------------------------
`default_nettype none

module kcl_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire kcl_pkg::result_t in_word,
  output      logic             in_stall,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      kcl_pkg::result_t out_word
);

  logic             skid_valid;
  kcl_pkg::result_t skid_word;
  logic             in_acc;
  logic             pop;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      // output held: park the new word in the skid register
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_acc) begin
        out_word <= in_word;
      end
    end else if (in_acc) begin
      if (out_valid) begin
        skid_word <= in_word;
      end else begin
        out_word <= in_word;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/keypad_code_lock_core.sv
// ---------------------------------------------------------------------------
// keypad_code_lock_core
// multi-channel keypad code lock, one key symbol in, one event word out
// ---------------------------------------------------------------------------
// usage
//   key channel: key_valid / key_stall / key_symbol, one key per word
//   result channel: result_valid / result_stall / event_kind, matched_channel
//   config: cfg_write with cfg_index and cfg_data, write only while idle
// result: each taken key's event word is registered in the output buffer
// throughput: one key per cycle unless key_stall is high; the star compare
//   runs over the row of buffer cells in the same cycle
// reset: rst clears code registers, entry state and the output buffer
// stall: results sit in a two-word buffer; key_stall rises only when both
//   words are full, and drops the cycle after the receiver takes one
// ---------------------------------------------------------------------------
`default_nettype none

`include "keypad_code_lock_core_defines.svh"

module keypad_code_lock_core #(
  parameter int NUM_CHANNELS = 4,
  parameter int MAX_DIGITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kcl_pkg::CODE_W-1:0]        cfg_data,
  input  wire logic                              key_valid,
  output      logic                              key_stall,
  input  wire logic [kcl_pkg::SYM_W-1:0]         key_symbol,
  output      logic                              result_valid,
  input  wire logic                              result_stall,
  output      logic [kcl_pkg::KIND_W-1:0]        event_kind,
  output      logic [kcl_pkg::CHAN_W-1:0]        matched_channel
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [kcl_pkg::CODE_W-1:0] code_digits [kcl_pkg::CH_SLOTS];
  logic [kcl_pkg::LEN_W-1:0]  code_len    [kcl_pkg::CH_SLOTS];

  logic             entry_open;
  logic [CNT_W-1:0] entry_count;
  logic             entry_overflow;

  logic             key_acc;
  logic             is_star;
  logic             buf_full;
  logic             store_key;
  kcl_pkg::result_t res;
  kcl_pkg::result_t res_out;

  logic [NUM_CHANNELS-1:0] match_chain [MAX_DIGITS+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < kcl_pkg::CH_SLOTS; ch++) begin
        code_digits[ch] <= '0;
        code_len[ch]    <= '0;
      end
    end else if (cfg_write) begin
      unique case (kcl_pkg::cfg_reg_t'(cfg_index))
        kcl_pkg::REG_CODE_A: code_digits[0] <= cfg_data;
        kcl_pkg::REG_CODE_B: code_digits[1] <= cfg_data;
        kcl_pkg::REG_CODE_C: code_digits[2] <= cfg_data;
        kcl_pkg::REG_CODE_D: code_digits[3] <= cfg_data;
        kcl_pkg::REG_LEN_A:  code_len[0]    <= cfg_data[kcl_pkg::LEN_W-1:0];
        kcl_pkg::REG_LEN_B:  code_len[1]    <= cfg_data[kcl_pkg::LEN_W-1:0];
        kcl_pkg::REG_LEN_C:  code_len[2]    <= cfg_data[kcl_pkg::LEN_W-1:0];
        kcl_pkg::REG_LEN_D:  code_len[3]    <= cfg_data[kcl_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign key_acc   = key_valid && !key_stall;
  assign is_star   = key_symbol == kcl_pkg::SYM_STAR;
  assign buf_full  = entry_count == CNT_W'(MAX_DIGITS);
  assign store_key = key_acc && entry_open && !is_star && !buf_full;

  // entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_open     <= 1'b0;
      entry_count    <= '0;
      entry_overflow <= 1'b0;
    end else if (key_acc) begin
      if (is_star) begin
        entry_open     <= !entry_open;
        entry_count    <= '0;
        entry_overflow <= 1'b0;
      end else if (entry_open) begin
        if (buf_full) begin
          entry_overflow <= 1'b1;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end
    end
  end

  // chain seed: length must equal the entry count
  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      match_chain[0][ch] = code_len[ch] == kcl_pkg::LEN_W'(entry_count);
    end
  end

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    logic [NUM_CHANNELS-1:0][kcl_pkg::SYM_W-1:0] code_sym;

    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_sym
      assign code_sym[ch] = code_digits[ch][kcl_pkg::SYM_W*k +: kcl_pkg::SYM_W];
    end

    kcl_cell #(
      .NUM_CHANNELS(NUM_CHANNELS)
    ) u_cell (
      .clk      (clk),
      .wr_en    (store_key && (entry_count == CNT_W'(k))),
      .sym_in   (key_symbol),
      .active   (CNT_W'(k) < entry_count),
      .code_sym (code_sym),
      .match_in (match_chain[k]),
      .match_out(match_chain[k+1])
    );
  end

  // result of the accepted key
  always_comb begin
    res.kind = kcl_pkg::EV_NONE;
    res.chan = '0;
    if (is_star) begin
      if (entry_open) begin
        res.kind = kcl_pkg::EV_REJECT;
        if ((entry_count != '0) && !entry_overflow) begin
          // lowest matching channel wins
          for (int ch = NUM_CHANNELS - 1; ch >= 0; ch--) begin
            if (match_chain[MAX_DIGITS][ch]) begin
              res.kind = kcl_pkg::EV_ACTUATE;
              res.chan = kcl_pkg::CHAN_W'(ch);
            end
          end
        end
      end
    end else if (!entry_open) begin
      res.kind = kcl_pkg::EV_STRAY;
    end
  end

  kcl_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_valid),
    .in_word  (res),
    .in_stall (key_stall),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_word (res_out)
  );

  assign event_kind      = res_out.kind;
  assign matched_channel = res_out.chan;

  `KCL_ASSERT(a_count_bound, 1'b1, entry_count <= CNT_W'(MAX_DIGITS), "entry count past limit")
  `KCL_ASSERT(a_ovf_full, entry_overflow, entry_open && buf_full, "overflow without full entry")
  `KCL_ASSERT(a_closed_clear, !entry_open, (entry_count == '0) && !entry_overflow, "stale entry")
  `KCL_ASSERT_NEXT(a_star_close, key_acc && is_star && entry_open, !entry_open, "entry left open")

endmodule

`default_nettype wire

FILE: tb/sv/keypad_code_lock_core_test.sv
// ---------------------------------------------------------------------------
// keypad_code_lock_core_test
// self-checking bench for the keypad code lock: random gaps on the key
// channel, random stalls on the result channel, a behavioral copy of the
// lock predicting each event word, code registers reloaded between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypad_code_lock_core_test;

  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int ENTRY_DEPTH  = 16;
  localparam logic [kcl_pkg::SYM_W-1:0] KEY_HASH = 4'd15;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kcl_pkg::CODE_W-1:0]    cfg_data = '0;
  logic                          key_valid = 1'b0;
  logic                          key_stall;
  logic [kcl_pkg::SYM_W-1:0]     key_symbol = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [kcl_pkg::KIND_W-1:0]    event_kind;
  logic [kcl_pkg::CHAN_W-1:0]    matched_channel;

  keypad_code_lock_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .key_valid       (key_valid),
    .key_stall       (key_stall),
    .key_symbol      (key_symbol),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .event_kind      (event_kind),
    .matched_channel (matched_channel)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // lock state as the bench sees it
  logic [kcl_pkg::CODE_W-1:0] code_digits [kcl_pkg::CH_SLOTS];
  logic [kcl_pkg::LEN_W-1:0]  code_len [kcl_pkg::CH_SLOTS];
  logic [kcl_pkg::CODE_W-1:0] plan_digits [kcl_pkg::CH_SLOTS];
  logic [kcl_pkg::LEN_W-1:0]  plan_len [kcl_pkg::CH_SLOTS];
  logic                       entry_open;
  logic [kcl_pkg::SYM_W-1:0]  entry_syms [ENTRY_DEPTH];
  int                         entry_len;
  logic                       entry_over;

  kcl_pkg::result_t pending_events [$];

  int idle_pct = 33;
  int n_errors = 0;
  int n_keys = 0;
  int n_results = 0;
  int n_actuate = 0;
  int n_reject = 0;
  int n_stray = 0;
  int n_overflow = 0;
  int n_settings = 0;

  task automatic report_mismatch(input string msg);
    $display("error @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic bit code_fits(input int ch);
    if (code_len[ch] == 0 || code_len[ch] != entry_len || code_len[ch] > ENTRY_DEPTH)
      return 1'b0;
    for (int k = 0; k < code_len[ch]; k++) begin
      if (code_digits[ch][4*k +: 4] != entry_syms[k])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the lock by one key and return the event word it gives
  function automatic kcl_pkg::result_t unlock_outcome(input logic [kcl_pkg::SYM_W-1:0] sym);
    kcl_pkg::result_t r;
    r.kind = kcl_pkg::EV_NONE;
    r.chan = '0;
    if (sym == kcl_pkg::SYM_STAR) begin
      if (!entry_open) begin
        entry_open = 1'b1;
      end else begin
        r.kind = kcl_pkg::EV_REJECT;
        if (entry_over)
          n_overflow++;
        if (entry_len != 0 && !entry_over) begin
          // scan downward so the lowest matching channel is the one left
          for (int ch = kcl_pkg::CH_SLOTS - 1; ch >= 0; ch--) begin
            if (code_fits(ch)) begin
              r.kind = kcl_pkg::EV_ACTUATE;
              r.chan = kcl_pkg::CHAN_W'(ch);
            end
          end
        end
        entry_open = 1'b0;
      end
      entry_len  = 0;
      entry_over = 1'b0;
    end else if (!entry_open) begin
      r.kind = kcl_pkg::EV_STRAY;
    end else if (entry_len < ENTRY_DEPTH) begin
      entry_syms[entry_len] = sym;
      entry_len++;
    end else begin
      entry_over = 1'b1;
    end
    return r;
  endfunction

  task automatic send_key(input logic [kcl_pkg::SYM_W-1:0] sym);
    while ($urandom_range(99) < idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid  <= 1'b1;
    key_symbol <= sym;
    do @(posedge clk); while (key_stall);
    pending_events.push_back(unlock_outcome(sym));
    n_keys++;
  endtask

  task automatic hold_until_drained();
    key_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input kcl_pkg::cfg_reg_t idx,
                           input logic [kcl_pkg::CODE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      kcl_pkg::REG_CODE_A: code_digits[0] = data;
      kcl_pkg::REG_CODE_B: code_digits[1] = data;
      kcl_pkg::REG_CODE_C: code_digits[2] = data;
      kcl_pkg::REG_CODE_D: code_digits[3] = data;
      kcl_pkg::REG_LEN_A:  code_len[0] = data[kcl_pkg::LEN_W-1:0];
      kcl_pkg::REG_LEN_B:  code_len[1] = data[kcl_pkg::LEN_W-1:0];
      kcl_pkg::REG_LEN_C:  code_len[2] = data[kcl_pkg::LEN_W-1:0];
      kcl_pkg::REG_LEN_D:  code_len[3] = data[kcl_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // length words carry random upper bits, only the low field counts
  task automatic load_codes();
    hold_until_drained();
    write_reg(kcl_pkg::REG_CODE_A, plan_digits[0]);
    write_reg(kcl_pkg::REG_CODE_B, plan_digits[1]);
    write_reg(kcl_pkg::REG_CODE_C, plan_digits[2]);
    write_reg(kcl_pkg::REG_CODE_D, plan_digits[3]);
    write_reg(kcl_pkg::REG_LEN_A, {$urandom, 27'($urandom), plan_len[0]});
    write_reg(kcl_pkg::REG_LEN_B, {$urandom, 27'($urandom), plan_len[1]});
    write_reg(kcl_pkg::REG_LEN_C, {$urandom, 27'($urandom), plan_len[2]});
    write_reg(kcl_pkg::REG_LEN_D, {$urandom, 27'($urandom), plan_len[3]});
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic send_entry(input string keys);
    for (int i = 0; i < keys.len(); i++) begin
      if (keys[i] == "*")
        send_key(kcl_pkg::SYM_STAR);
      else if (keys[i] == "#")
        send_key(KEY_HASH);
      else
        send_key(kcl_pkg::SYM_W'(keys[i] - "0"));
    end
  endtask

  task automatic randomize_codes();
    int pick;
    logic [kcl_pkg::SYM_W-1:0] nib;
    for (int ch = 0; ch < kcl_pkg::CH_SLOTS; ch++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        plan_len[ch] = 5'd0;
      else if (pick < 20)
        plan_len[ch] = 5'd16;
      else if (pick < 25)
        plan_len[ch] = kcl_pkg::LEN_W'($urandom_range(17, 31));
      else
        plan_len[ch] = kcl_pkg::LEN_W'($urandom_range(1, 8));
      for (int k = 0; k < ENTRY_DEPTH; k++) begin
        nib = kcl_pkg::SYM_W'($urandom_range(15));
        // mostly keep star out of codes so that matches stay reachable
        if (nib == kcl_pkg::SYM_STAR && $urandom_range(3) != 0)
          nib = KEY_HASH;
        plan_digits[ch][4*k +: 4] = nib;
      end
      // duplicate a lower channel now and then so priority gets exercised
      if (ch > 0 && $urandom_range(3) == 0) begin
        pick = $urandom_range(ch - 1);
        plan_digits[ch] = plan_digits[pick];
        plan_len[ch]    = plan_len[pick];
      end
    end
    load_codes();
  endtask

  // mostly framed entries (real codes, near misses, odd lengths), some noise
  task automatic run_traffic(input int n_target);
    int start;
    int ch;
    int len;
    logic [kcl_pkg::SYM_W-1:0] syms [$];
    logic [kcl_pkg::SYM_W-1:0] s;
    bit paused;
    start  = n_keys;
    paused = 1'b0;
    while (n_keys - start < n_target) begin
      if (!paused && n_keys - start >= n_target / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      syms.delete();
      if ($urandom_range(99) < 75) begin
        ch  = $urandom_range(kcl_pkg::CH_SLOTS - 1);
        len = code_len[ch];
        if (len >= 1 && len <= ENTRY_DEPTH && $urandom_range(99) < 60) begin
          for (int k = 0; k < len; k++)
            syms.push_back(code_digits[ch][4*k +: 4]);
        end else begin
          len = $urandom_range(0, ENTRY_DEPTH + 2);
          for (int k = 0; k < len; k++) begin
            s = kcl_pkg::SYM_W'($urandom_range(0, 14));
            if (s == kcl_pkg::SYM_STAR)
              s = KEY_HASH;
            syms.push_back(s);
          end
        end
        if (syms.size() != 0 && $urandom_range(99) < 20)
          syms[$urandom_range(syms.size() - 1)] ^= kcl_pkg::SYM_W'($urandom_range(1, 15));
        send_key(kcl_pkg::SYM_STAR);
        foreach (syms[i])
          send_key(syms[i]);
        send_key(kcl_pkg::SYM_STAR);
      end else begin
        repeat ($urandom_range(1, 3))
          send_key(kcl_pkg::SYM_W'($urandom_range(15)));
      end
    end
  endtask

  // all lengths are zero after reset, so nothing can open the lock
  task automatic test_locked_after_reset();
    send_key(4'd0);
    send_key(KEY_HASH);
    send_entry("*1*");
  endtask

  task automatic test_directed_codes();
    plan_digits[0] = 64'h0000_0000_0000_4321;
    plan_len[0]    = 5'd4;
    plan_digits[1] = 64'h0123_4567_89AB_CDFF;
    plan_len[1]    = 5'd16;
    plan_digits[2] = 64'h0000_0000_0000_000F;
    plan_len[2]    = 5'd1;
    // same code as channel 0 below unused upper symbols
    plan_digits[3] = 64'hDEAD_BEEF_0000_4321;
    plan_len[3]    = 5'd4;
    load_codes();
    send_entry("**");
    send_entry("*#*");
    send_entry("*1243*");
    send_entry("*1234*");
  endtask

  task automatic test_extreme_codes();
    for (int ch = 0; ch < kcl_pkg::CH_SLOTS; ch++)
      plan_digits[ch] = '1;
    plan_len[0] = 5'd16;
    plan_len[1] = 5'd31;
    plan_len[2] = 5'd0;
    plan_len[3] = 5'd17;
    load_codes();
    run_traffic(150);
    for (int ch = 0; ch < kcl_pkg::CH_SLOTS; ch++)
      plan_digits[ch] = '0;
    plan_len[0] = 5'd1;
    plan_len[1] = 5'd16;
    plan_len[2] = 5'd16;
    plan_len[3] = 5'd31;
    load_codes();
    run_traffic(150);
  endtask

  task automatic test_random_codes(input int n_phases);
    for (int p = 0; p < n_phases; p++) begin
      randomize_codes();
      run_traffic(250);
    end
  endtask

  task automatic test_no_idle_stretch();
    idle_pct = 0;
    randomize_codes();
    run_traffic(250);
    idle_pct = 33;
  endtask

  always @(posedge clk) begin
    result_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin : check_results
    kcl_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event word kind=%0d chan=%0d",
                                  event_kind, matched_channel));
      end else begin
        want = pending_events.pop_front();
        n_results++;
        case (want.kind)
          kcl_pkg::EV_ACTUATE: n_actuate++;
          kcl_pkg::EV_REJECT:  n_reject++;
          kcl_pkg::EV_STRAY:   n_stray++;
          default: ;
        endcase
        if (event_kind !== want.kind)
          report_mismatch($sformatf("word %0d: event_kind %0d, want %0d",
                                    n_results, event_kind, want.kind));
        if (matched_channel !== want.chan)
          report_mismatch($sformatf("word %0d: matched_channel %0d, want %0d",
                                    n_results, matched_channel, want.chan));
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("error: run did not finish in time");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int waited;
    for (int ch = 0; ch < kcl_pkg::CH_SLOTS; ch++) begin
      code_digits[ch] = '0;
      code_len[ch]    = '0;
    end
    entry_open = 1'b0;
    entry_len  = 0;
    entry_over = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_locked_after_reset();
    test_directed_codes();
    test_extreme_codes();
    test_random_codes(2);
    test_no_idle_stretch();
    test_random_codes(2);

    key_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_events.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d event words never arrived", pending_events.size()));
    repeat (4) @(posedge clk);

    $display("ran %0d keys through %0d code settings, %0d event words checked",
             n_keys, n_settings, n_results);
    $display("saw %0d actuations, %0d rejects (%0d after overflow), %0d stray keys",
             n_actuate, n_reject, n_overflow, n_stray);
    if (n_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
